// ===== hw/rtl/slx_pkg.sv =====
package slx_pkg;

  // Token kinds
  localparam logic [5:0] K_EOF    = 6'd0;
  localparam logic [5:0] K_INT    = 6'd1;
  localparam logic [5:0] K_STR    = 6'd2;
  localparam logic [5:0] K_IDENT  = 6'd3;
  localparam logic [5:0] K_KEY0   = 6'd4;
  localparam logic [5:0] K_LPAREN = 6'd17;
  localparam logic [5:0] K_RPAREN = 6'd18;
  localparam logic [5:0] K_LBRACK = 6'd19;
  localparam logic [5:0] K_RBRACK = 6'd20;
  localparam logic [5:0] K_LBRACE = 6'd21;
  localparam logic [5:0] K_RBRACE = 6'd22;
  localparam logic [5:0] K_ASSIGN = 6'd23;
  localparam logic [5:0] K_COMMA  = 6'd24;
  localparam logic [5:0] K_SEMI   = 6'd25;
  localparam logic [5:0] K_ADD    = 6'd26;
  localparam logic [5:0] K_SUB    = 6'd27;
  localparam logic [5:0] K_MUL    = 6'd28;
  localparam logic [5:0] K_DIV    = 6'd29;
  localparam logic [5:0] K_MOD    = 6'd30;
  localparam logic [5:0] K_NOT    = 6'd31;
  localparam logic [5:0] K_LTH    = 6'd32;
  localparam logic [5:0] K_GTH    = 6'd33;
  localparam logic [5:0] K_LEQ    = 6'd34;
  localparam logic [5:0] K_GEQ    = 6'd35;
  localparam logic [5:0] K_EQL    = 6'd36;
  localparam logic [5:0] K_NEQ    = 6'd37;

  // Error codes
  localparam logic [3:0] E_NONE       = 4'd0;
  localparam logic [3:0] E_AFTER_INT  = 4'd1;
  localparam logic [3:0] E_HEX        = 4'd2;
  localparam logic [3:0] E_UNTERM_STR = 4'd3;
  localparam logic [3:0] E_ESCAPE     = 4'd4;
  localparam logic [3:0] E_CHAR_LONG  = 4'd5;
  localparam logic [3:0] E_COMMENT    = 4'd6;
  localparam logic [3:0] E_BAD_START  = 4'd7;
  localparam logic [3:0] E_IDENT_LONG = 4'd8;

  localparam int NUM_KW = 13;
  localparam logic [23:0] LINE_MAX = 24'hFFFFFF;

  // Default sizes
  localparam int IDENT_MAX_DEF         = 32;
  localparam int CHARLIT_MAX_DEF       = 8;
  localparam int COMMENT_DEPTH_MAX_DEF = 255;

  typedef enum logic [2:0] {
    M_IDLE, M_HELD, M_INT, M_IDENT, M_STR, M_LINE, M_BLOCK
  } mode_t;

  typedef enum logic [2:0] {
    C_WAIT, C_STEP, C_START, C_FRD, C_FEMIT, C_HALT
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic start;
    logic flush_emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic step_fail;
    logic step_start;
    logic step_flush;
    logic start_fail;
    logic flush_last;
  } sts_t;

  typedef struct packed {
    logic [5:0]         kind;
    logic signed [63:0] number;
    logic [7:0]         char_out;
    logic               char_valid;
    logic               last;
    logic [3:0]         error_code;
    logic [23:0]        line;
  } item_t;

  function automatic logic is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic is_space(logic [7:0] b);
    return b == " " || (b >= 8'd9 && b <= 8'd13);
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_val(logic [7:0] b);
    logic [7:0] d;
    d = 8'h00;
    if (is_digit(b)) begin
      d = b - "0";
      return {1'b1, d[3:0]};
    end
    if (b >= "a" && b <= "f") begin
      d = b - "a" + 8'd10;
      return {1'b1, d[3:0]};
    end
    if (b >= "A" && b <= "F") begin
      d = b - "A" + 8'd10;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

  // Zero when b is not a lone punctuation byte
  function automatic logic [5:0] single_kind(logic [7:0] b);
    logic [5:0] k;
    k = K_EOF;
    unique case (b)
      "(": k = K_LPAREN;
      ")": k = K_RPAREN;
      "[": k = K_LBRACK;
      "]": k = K_RBRACK;
      "{": k = K_LBRACE;
      "}": k = K_RBRACE;
      ",": k = K_COMMA;
      ";": k = K_SEMI;
      "*": k = K_MUL;
      "%": k = K_MOD;
      default: k = K_EOF;
    endcase
    return k;
  endfunction

  function automatic logic [63:0] kw_text(int k);
    logic [63:0] s;
    s = 64'd0;
    unique case (k)
      0:  s = "true";
      1:  s = "false";
      2:  s = "null";
      3:  s = "global";
      4:  s = "extern";
      5:  s = "local";
      6:  s = "function";
      7:  s = "if";
      8:  s = "else";
      9:  s = "while";
      10: s = "break";
      11: s = "continue";
      12: s = "return";
      default: s = 64'd0;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] kw_len(int k);
    logic [3:0] n;
    n = 4'd0;
    unique case (k)
      0, 2, 8:       n = 4'd4;
      1, 5, 9, 10:   n = 4'd5;
      3, 4, 12:      n = 4'd6;
      6, 11:         n = 4'd8;
      7:             n = 4'd2;
      default:       n = 4'd0;
    endcase
    return n;
  endfunction

  // Character p of keyword k; first character is p = 0
  function automatic logic [7:0] kw_char(int k, logic [2:0] p);
    logic [63:0] s;
    int          n;
    s = kw_text(k);
    n = int'(kw_len(k));
    if (int'(p) >= n) return 8'd0;
    return s[8*(n-1-int'(p)) +: 8];
  endfunction

endpackage

// ===== hw/rtl/slx_in_if.sv =====
interface slx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink (input valid, input char_in, output ready);
endinterface

// ===== hw/rtl/slx_out_if.sv =====
interface slx_out_if;
  logic               valid;
  logic               ready;
  logic [5:0]         kind;
  logic signed [63:0] number;
  logic [7:0]         char_out;
  logic               char_valid;
  logic               last;
  logic [3:0]         error_code;
  logic [23:0]        line;

  modport source (output valid, output kind, output number, output char_out,
                  output char_valid, output last, output error_code, output line,
                  input ready);
  modport sink (input valid, input kind, input number, input char_out,
                input char_valid, input last, input error_code, input line,
                output ready);
endinterface

// ===== hw/rtl/slx_ram.sv =====
module slx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/slx_ctrl.sv =====
module slx_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  slx_pkg::sts_t sts,
  output slx_pkg::cmd_t cmd
);
  slx_pkg::ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= slx_pkg::C_WAIT;
    else     state <= state_next;
  end

  // Sequencing: take byte, run mode step, then optional flush and token start
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      slx_pkg::C_WAIT: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = slx_pkg::C_STEP;
        end
      end
      slx_pkg::C_STEP: begin
        if (sts.out_free) begin
          cmd.step = 1'b1;
          priority if (sts.step_fail)  state_next = slx_pkg::C_HALT;
          else if (sts.step_flush)     state_next = slx_pkg::C_FRD;
          else if (sts.step_start)     state_next = slx_pkg::C_START;
          else                         state_next = slx_pkg::C_WAIT;
        end
      end
      slx_pkg::C_START: begin
        if (sts.out_free) begin
          cmd.start  = 1'b1;
          state_next = sts.start_fail ? slx_pkg::C_HALT : slx_pkg::C_WAIT;
        end
      end
      slx_pkg::C_FRD: state_next = slx_pkg::C_FEMIT;
      slx_pkg::C_FEMIT: begin
        if (sts.out_free) begin
          cmd.flush_emit = 1'b1;
          state_next     = sts.flush_last ? slx_pkg::C_START : slx_pkg::C_FRD;
        end
      end
      // Halted: bytes are still taken and dropped without any result
      slx_pkg::C_HALT: begin
        in_ready   = !rst;
        state_next = slx_pkg::C_HALT;
      end
      default: state_next = slx_pkg::C_WAIT;
    endcase
  end
endmodule

// ===== hw/rtl/slx_datapath.sv =====
module slx_datapath #(
  parameter int IDENT_MAX         = slx_pkg::IDENT_MAX_DEF,
  parameter int CHARLIT_MAX       = slx_pkg::CHARLIT_MAX_DEF,
  parameter int COMMENT_DEPTH_MAX = slx_pkg::COMMENT_DEPTH_MAX_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  slx_pkg::cmd_t  cmd,
  output slx_pkg::sts_t  sts,
  input  logic [7:0]     char_in,
  input  logic           out_ready,
  output logic           out_valid,
  output slx_pkg::item_t out_item
);
  localparam int LW = $clog2(IDENT_MAX + 1);
  localparam int AW = $clog2(IDENT_MAX);
  localparam int DW = $clog2(COMMENT_DEPTH_MAX + 1);

  typedef struct packed {
    slx_pkg::mode_t          mode;
    logic [7:0]              held;
    logic                    hvalid;
    logic [63:0]             acc;
    logic                    neg;
    logic [DW-1:0]           depth;
    logic                    sq;
    logic [1:0]              esc;
    logic [3:0]              hexh;
    logic [LW-1:0]           ilen;
    logic [3:0]              lcount;
    logic [slx_pkg::NUM_KW-1:0] kwm;
    logic [23:0]             line;
  } lex_t;

  // State after reset: idle, line one, everything else clear
  localparam lex_t LEX_RESET = '{
    mode: slx_pkg::M_IDLE, held: '0, hvalid: 1'b0, acc: '0, neg: 1'b0,
    depth: '0, sq: 1'b0, esc: '0, hexh: '0, ilen: '0, lcount: '0, kwm: '0,
    line: 24'd1
  };

  lex_t              r, ns, nt;
  logic [7:0]        b;
  logic [LW-1:0]     fidx;
  logic [7:0]        ram_q;

  slx_pkg::item_t    si, ti, fi;
  logic              sv, s_start, s_flush, s_fail, s_we;
  logic              tv, t_fail, t_we;
  logic [3:0]        s_err, t_err;
  logic [4:0]        hx;
  logic              sc_do;
  logic [7:0]        sc_val;
  logic              pair;
  logic [DW-1:0]     dec_depth;
  logic [5:0]        sk;
  logic              kw_hit;
  logic [5:0]        kw_kind;

  // Narrow keyword candidates by the character at position p
  function automatic logic [slx_pkg::NUM_KW-1:0] kw_next(logic [slx_pkg::NUM_KW-1:0] m,
                                                          logic [LW-1:0] p,
                                                          logic [7:0] c);
    logic [slx_pkg::NUM_KW-1:0] n;
    n = '0;
    for (int k = 0; k < slx_pkg::NUM_KW; k++) begin
      n[k] = m[k] && (p < LW'(slx_pkg::kw_len(k))) &&
             (slx_pkg::kw_char(k, p[2:0]) == c);
    end
    return n;
  endfunction

  // Keyword match at end of identifier
  always_comb begin
    kw_hit  = 1'b0;
    kw_kind = slx_pkg::K_EOF;
    for (int k = slx_pkg::NUM_KW - 1; k >= 0; k--) begin
      if (r.kwm[k] && LW'(slx_pkg::kw_len(k)) == r.ilen) begin
        kw_hit  = 1'b1;
        kw_kind = 6'(int'(slx_pkg::K_KEY0) + k);
      end
    end
  end

  // One byte in the current mode
  always_comb begin
    ns        = r;
    sv        = 1'b0;
    si        = '0;
    si.last   = 1'b1;
    si.line   = r.line;
    s_start   = 1'b0;
    s_flush   = 1'b0;
    s_fail    = 1'b0;
    s_we      = 1'b0;
    s_err     = slx_pkg::E_NONE;
    hx        = slx_pkg::hex_val(b);
    sc_do     = 1'b0;
    sc_val    = 8'd0;
    pair      = 1'b0;
    dec_depth = (r.depth != '0) ? r.depth - DW'(1) : '0;
    unique case (r.mode)
      slx_pkg::M_HELD: begin
        ns.hvalid = 1'b0;
        ns.held   = 8'd0;
        ns.mode   = slx_pkg::M_IDLE;
        priority if (r.held == "/") begin
          priority if (b == "/") ns.mode = slx_pkg::M_LINE;
          else if (b == "*") begin
            ns.depth = DW'(1);
            ns.mode  = slx_pkg::M_BLOCK;
          end else begin
            sv = 1'b1; si.kind = slx_pkg::K_DIV; s_start = 1'b1;
          end
        end else if (r.held == "=" || r.held == "!" || r.held == "<" || r.held == ">") begin
          sv = 1'b1;
          if (b == "=") begin
            priority if (r.held == "=") si.kind = slx_pkg::K_EQL;
            else if (r.held == "!")     si.kind = slx_pkg::K_NEQ;
            else if (r.held == "<")     si.kind = slx_pkg::K_LEQ;
            else                        si.kind = slx_pkg::K_GEQ;
          end else begin
            s_start = 1'b1;
            priority if (r.held == "=") si.kind = slx_pkg::K_ASSIGN;
            else if (r.held == "!")     si.kind = slx_pkg::K_NOT;
            else if (r.held == "<")     si.kind = slx_pkg::K_LTH;
            else                        si.kind = slx_pkg::K_GTH;
          end
        end else if (r.held == "+" || r.held == "-") begin
          if (slx_pkg::is_digit(b)) begin
            ns.acc  = {56'd0, b - "0"};
            ns.neg  = (r.held == "-");
            ns.mode = slx_pkg::M_INT;
          end else begin
            sv = 1'b1; s_start = 1'b1;
            si.kind = (r.held == "+") ? slx_pkg::K_ADD : slx_pkg::K_SUB;
          end
        end else begin
          s_start = 1'b1;
        end
      end
      slx_pkg::M_INT: begin
        priority if (slx_pkg::is_digit(b)) begin
          ns.acc = (r.acc << 3) + (r.acc << 1) + {56'd0, b - "0"};
        end else if (slx_pkg::is_alpha(b) || b == "_") begin
          s_fail = 1'b1; s_err = slx_pkg::E_AFTER_INT;
        end else begin
          sv = 1'b1; s_start = 1'b1;
          si.kind   = slx_pkg::K_INT;
          si.number = r.neg ? -r.acc : r.acc;
          ns.mode   = slx_pkg::M_IDLE;
        end
      end
      slx_pkg::M_IDENT: begin
        if (slx_pkg::is_alpha(b) || slx_pkg::is_digit(b) || b == "_") begin
          if (r.ilen >= LW'(IDENT_MAX)) begin
            s_fail = 1'b1; s_err = slx_pkg::E_IDENT_LONG;
          end else begin
            s_we    = 1'b1;
            ns.ilen = r.ilen + LW'(1);
            ns.kwm  = kw_next(r.kwm, r.ilen, b);
          end
        end else begin
          ns.mode = slx_pkg::M_IDLE;
          s_start = 1'b1;
          if (kw_hit) begin
            sv = 1'b1; si.kind = kw_kind;
          end else begin
            s_flush = 1'b1;
          end
        end
      end
      slx_pkg::M_STR: begin
        if (b == 8'd0) begin
          s_fail = 1'b1; s_err = slx_pkg::E_UNTERM_STR;
        end else begin
          unique case (r.esc)
            2'd0: begin
              priority if (b == (r.sq ? 8'h27 : 8'h22)) begin
                sv = 1'b1;
                if (r.sq) begin
                  si.kind = slx_pkg::K_INT; si.number = r.acc;
                end else begin
                  si.kind = slx_pkg::K_STR;
                end
                ns.mode = slx_pkg::M_IDLE;
              end else if (b == "\\") begin
                ns.esc = 2'd1;
              end else begin
                sc_do = 1'b1; sc_val = b;
              end
            end
            2'd1: begin
              ns.esc = 2'd0;
              sc_do  = 1'b1;
              unique case (b)
                8'h27, 8'h22, "\\": sc_val = b;
                "n": sc_val = 8'h0A;
                "t": sc_val = 8'h09;
                "r": sc_val = 8'h0D;
                "f": sc_val = 8'h0C;
                "0": sc_val = 8'h00;
                "x": begin sc_do = 1'b0; ns.esc = 2'd2; end
                default: begin
                  sc_do = 1'b0; s_fail = 1'b1; s_err = slx_pkg::E_ESCAPE;
                end
              endcase
            end
            2'd2: begin
              if (!hx[4]) begin
                s_fail = 1'b1; s_err = slx_pkg::E_HEX;
              end else begin
                ns.hexh = hx[3:0]; ns.esc = 2'd3;
              end
            end
            default: begin
              if (!hx[4]) begin
                s_fail = 1'b1; s_err = slx_pkg::E_HEX;
              end else begin
                ns.esc = 2'd0; sc_do = 1'b1; sc_val = {r.hexh, hx[3:0]};
              end
            end
          endcase
          // Decoded string character or packed char literal byte
          if (sc_do) begin
            priority if (!r.sq) begin
              sv = 1'b1;
              si.kind = slx_pkg::K_STR; si.char_out = sc_val;
              si.char_valid = 1'b1; si.last = 1'b0;
            end else if (r.lcount >= 4'(CHARLIT_MAX)) begin
              s_fail = 1'b1; s_err = slx_pkg::E_CHAR_LONG;
            end else begin
              ns.acc    = r.acc | ({56'd0, sc_val} << {r.lcount[2:0], 3'b000});
              ns.lcount = r.lcount + 4'd1;
            end
          end
        end
      end
      slx_pkg::M_LINE: begin
        ns.mode = slx_pkg::M_IDLE;
        priority if (b == 8'd0) s_start = 1'b1;
        else if (b != 8'h0A)    ns.mode = slx_pkg::M_LINE;
        else                    ns.mode = slx_pkg::M_IDLE;
      end
      slx_pkg::M_BLOCK: begin
        if (b == 8'd0) begin
          s_fail = 1'b1; s_err = slx_pkg::E_COMMENT;
        end else begin
          if (r.hvalid) begin
            ns.hvalid = 1'b0;
            ns.held   = 8'd0;
            priority if (r.held == "/" && b == "*") begin
              pair = 1'b1;
              if (r.depth >= DW'(COMMENT_DEPTH_MAX)) begin
                s_fail = 1'b1; s_err = slx_pkg::E_COMMENT;
              end else begin
                ns.depth = r.depth + DW'(1);
              end
            end else if (r.held == "*" && b == "/") begin
              pair     = 1'b1;
              ns.depth = dec_depth;
              if (dec_depth == '0) ns.mode = slx_pkg::M_IDLE;
            end else begin
              pair = 1'b0;
            end
          end
          if (!pair && (b == "/" || b == "*")) begin
            ns.held = b; ns.hvalid = 1'b1;
          end
        end
      end
      default: s_start = 1'b1;
    endcase
    // Error item overrides anything formed above
    if (s_fail) begin
      sv = 1'b1;
      si = '0;
      si.last = 1'b1;
      si.error_code = s_err;
      si.line = r.line;
      s_start = 1'b0;
      s_flush = 1'b0;
    end
  end

  // Token start on byte b
  always_comb begin
    nt        = r;
    nt.mode   = slx_pkg::M_IDLE;
    tv        = 1'b0;
    ti        = '0;
    ti.last   = 1'b1;
    ti.line   = r.line;
    t_fail    = 1'b0;
    t_we      = 1'b0;
    t_err     = slx_pkg::E_NONE;
    sk        = slx_pkg::single_kind(b);
    priority if (b == 8'd0) begin
      tv = 1'b1; ti.kind = slx_pkg::K_EOF; nt.line = 24'd1;
    end else if (slx_pkg::is_space(b)) begin
      nt.mode = slx_pkg::M_IDLE;
    end else if (b == "#") begin
      nt.mode = slx_pkg::M_LINE;
    end else if (b == "/" || b == "=" || b == "!" || b == "<" || b == ">" ||
                 b == "+" || b == "-") begin
      nt.held = b; nt.hvalid = 1'b1; nt.mode = slx_pkg::M_HELD;
    end else if (sk != slx_pkg::K_EOF) begin
      tv = 1'b1; ti.kind = sk;
    end else if (slx_pkg::is_digit(b)) begin
      nt.acc = {56'd0, b - "0"}; nt.neg = 1'b0; nt.mode = slx_pkg::M_INT;
    end else if (slx_pkg::is_alpha(b) || b == "_") begin
      t_we    = 1'b1;
      nt.ilen = LW'(1);
      nt.kwm  = kw_next('1, '0, b);
      nt.mode = slx_pkg::M_IDENT;
    end else if (b == 8'h27 || b == 8'h22) begin
      nt.sq = (b == 8'h27); nt.lcount = 4'd0; nt.acc = 64'd0; nt.esc = 2'd0;
      nt.mode = slx_pkg::M_STR;
    end else begin
      t_fail = 1'b1; t_err = slx_pkg::E_BAD_START;
      tv = 1'b1; ti.kind = slx_pkg::K_EOF; ti.error_code = t_err;
    end
  end

  // Identifier character replay
  always_comb begin
    fi            = '0;
    fi.kind       = slx_pkg::K_IDENT;
    fi.char_out   = ram_q;
    fi.char_valid = 1'b1;
    fi.last       = (fidx + LW'(1) == r.ilen);
    fi.line       = r.line;
  end

  slx_ram #(.WIDTH(8), .DEPTH(IDENT_MAX)) u_ident_ram (
    .clk   (clk),
    .we    ((cmd.step && s_we) || (cmd.start && t_we)),
    .waddr (cmd.start ? '0 : r.ilen[AW-1:0]),
    .wdata (b),
    .raddr (fidx[AW-1:0]),
    .rdata (ram_q)
  );

  assign sts.out_free   = !out_valid || out_ready;
  assign sts.step_fail  = s_fail;
  assign sts.step_start = s_start;
  assign sts.step_flush = s_flush;
  assign sts.start_fail = t_fail;
  assign sts.flush_last = fi.last;

  // Byte latch, lexer state and line count
  always_ff @(posedge clk) begin
    if (cmd.load) b <= char_in;
    if (rst) begin
      r        <= LEX_RESET;
      fidx     <= '0;
    end else begin
      if (cmd.load && char_in == 8'h0A && r.line != slx_pkg::LINE_MAX)
        r.line <= r.line + 24'd1;
      if (cmd.step)  r <= ns;
      if (cmd.start) r <= nt;
      if (cmd.step && s_flush) fidx <= '0;
      if (cmd.flush_emit)      fidx <= fidx + LW'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.step && sv) begin
      out_valid <= 1'b1;
    end else if (cmd.start && tv) begin
      out_valid <= 1'b1;
    end else if (cmd.flush_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.step && sv) out_item <= si;
    else if (cmd.start && tv)    out_item <= ti;
    else if (cmd.flush_emit)     out_item <= fi;
    else                         out_item <= out_item;
  end
endmodule

// ===== hw/rtl/source_code_lexer.sv =====
// Streaming tokenizer for a small scripting language.
// in_ch carries one source byte per transfer (char_in); byte 0 ends the text,
// emits an EOF item and returns the line count to one.
// out_ch carries result items: kind, number, char_out, char_valid, last,
// error_code and line. A token ends with an item that has last set.
// A byte inside a token, string or comment is latched and then taken through a
// mode step; a byte that arrives between tokens, or that closes a token, is
// then also taken through a token start. An identifier that is not a keyword
// replays its characters from the buffer RAM (registered read, then output),
// one item per character, before the token start.
// The next byte is taken once the previous one is fully processed; the
// output register lets the last result wait.
// If the receiver stalls, each mode step, token start or replayed character
// waits while the output register is still full; no item is dropped.
// Reset (rst, synchronous) clears all lexer state and sets the line to one;
// there is no clearing pass. An error emits one item with its code and line;
// after that each byte is still taken, one per cycle, but dropped without
// any result until reset.
module source_code_lexer #(
  parameter int IDENT_MAX         = slx_pkg::IDENT_MAX_DEF,
  parameter int CHARLIT_MAX       = slx_pkg::CHARLIT_MAX_DEF,
  parameter int COMMENT_DEPTH_MAX = slx_pkg::COMMENT_DEPTH_MAX_DEF
) (
  input logic     clk,
  input logic     rst,
  slx_in_if.sink  in_ch,
  slx_out_if.source out_ch
);
  slx_pkg::cmd_t  cmd;
  slx_pkg::sts_t  sts;
  slx_pkg::item_t item;
  logic           ovalid;

  slx_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  slx_datapath #(
    .IDENT_MAX         (IDENT_MAX),
    .CHARLIT_MAX       (CHARLIT_MAX),
    .COMMENT_DEPTH_MAX (COMMENT_DEPTH_MAX)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .char_in   (in_ch.char_in),
    .out_ready (out_ch.ready),
    .out_valid (ovalid),
    .out_item  (item)
  );

  assign out_ch.valid      = ovalid;
  assign out_ch.kind       = item.kind;
  assign out_ch.number     = item.number;
  assign out_ch.char_out   = item.char_out;
  assign out_ch.char_valid = item.char_valid;
  assign out_ch.last       = item.last;
  assign out_ch.error_code = item.error_code;
  assign out_ch.line       = item.line;
endmodule
